@@ rtl/core/population_std_deviation_top_macros.svh @@
// assertion macros shared by the population standard deviation block
`ifndef POPULATION_STD_DEVIATION_TOP_MACROS_SVH
`define POPULATION_STD_DEVIATION_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psd assertion failed");

// next-cycle implication, checked outside reset
`define PSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psd assertion failed");

`endif

@@ rtl/core/psd_pkg.sv @@
// types and constants of the population standard deviation block
package psd_pkg;

    localparam int STD_W       = 24;
    localparam int CNT_OUT_W   = 11;
    localparam int FUNC_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_FIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIN     = 2'd2;

    typedef enum logic [1:0] {
        K_ADD,
        K_ADD_FIN,
        K_FIN
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cmd_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_N,
        S_MUL_S,
        S_SQRT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/population_std_deviation_top.sv @@
// top level of the population standard deviation block
// population standard deviation of a stream of signed fixed-point samples. each
// input word carries a func code (add sample, add sample then finish, finish
// only; code 3 is dropped) and a sample. the block keeps a count, a sum and a
// sum of squares and on a finish returns floor(isqrt(N*sumsq - sum*sum) / N) in
// the sample format, the sample count, an empty-set flag (std_dev is then 0) and
// an overflow flag for samples dropped once MAX_SAMPLES were taken. every finish
// clears the accumulators. rate: sample words are accumulated one per cycle
// while the back end is idle. a finish holds the back end through the
// bit-serial multiply (N times the sum of squares, minus the squared sum), root
// and divide steps; an empty set skips them. a four-word command queue takes up
// to four more words while the back end is busy, after which full stays high
// until the back end frees a slot. a result register holds the finished word
// until it is popped; a finish that completes while that register is still
// occupied holds the back end until the pop.
module population_std_deviation_top #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input queue side
    input  logic                                  push,
    output logic                                  full,
    input  logic [psd_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    // result queue side
    output logic                                  empty,
    input  logic                                  pop,
    output logic [psd_pkg::STD_W-1:0]             o_std_dev,
    output logic [psd_pkg::CNT_OUT_W-1:0]         o_sample_count,
    output logic                                  o_empty_set,
    output logic                                  o_overflowed
);

    // width of one squared sample
    localparam int SQ_W = 2 * SAMPLE_WIDTH - 1;

    // command word from front to back
    psd_pkg::t_cmd_ctl               cmd;
    logic signed [SAMPLE_WIDTH-1:0]  cmd_sample;
    logic [SQ_W-1:0]                 cmd_square;
    logic                            cmd_take;

    // front: classify func code, square the sample, queue the command
    psd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_func   (i_func),
        .i_sample (i_sample),
        .o_full   (full),
        .o_cmd    (cmd),
        .o_sample (cmd_sample),
        .o_square (cmd_square),
        .i_take   (cmd_take)
    );

    // back: accumulate, and on finish run multiply, root and divide
    psd_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample       (cmd_sample),
        .i_square       (cmd_square),
        .o_take         (cmd_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_std_dev      (o_std_dev),
        .o_sample_count (o_sample_count),
        .o_empty_set    (o_empty_set),
        .o_overflowed   (o_overflowed)
    );

endmodule

@@ rtl/core/psd_front.sv @@
// front end: accepts words, classifies them, squares the sample, queues commands
module psd_front #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic [psd_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    output logic                                  o_full,
    output psd_pkg::t_cmd_ctl                     o_cmd,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample,
    output logic [2*SAMPLE_WIDTH-2:0]             o_square,
    input  logic                                  i_take
);

    localparam int SQ_W = 2 * SAMPLE_WIDTH - 1;

    psd_pkg::t_kind                   r_q_kind   [psd_pkg::QUEUE_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0]   r_q_sample [psd_pkg::QUEUE_DEPTH];
    logic [SQ_W-1:0]                  r_q_square [psd_pkg::QUEUE_DEPTH];
    logic [psd_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [psd_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [psd_pkg::QPTR_W:0]         r_fill, n_fill;

    psd_pkg::t_kind                   kind;
    logic                             func_ok;
    logic                             wr_en;
    logic                             rd_en;
    logic [SAMPLE_WIDTH-1:0]          mag;
    logic [2*SAMPLE_WIDTH-1:0]        sq_full;

    // func code to command kind, undefined code is dropped
    always_comb begin
        func_ok = 1'b1;
        kind    = psd_pkg::K_ADD;
        case (i_func)
            psd_pkg::FUNC_ADD:     kind = psd_pkg::K_ADD;
            psd_pkg::FUNC_ADD_FIN: kind = psd_pkg::K_ADD_FIN;
            psd_pkg::FUNC_FIN:     kind = psd_pkg::K_FIN;
            default:               func_ok = 1'b0;
        endcase
    end

    assign mag     = i_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_sample)
                                              : SAMPLE_WIDTH'(i_sample);
    assign sq_full = (2*SAMPLE_WIDTH)'(mag) * (2*SAMPLE_WIDTH)'(mag);

    assign o_full = (r_fill == (psd_pkg::QPTR_W+1)'(psd_pkg::QUEUE_DEPTH));
    assign wr_en  = i_push && !o_full && func_ok;
    assign rd_en  = i_take && (r_fill != '0);

    assign n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
    assign n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
    assign n_fill   = r_fill + (psd_pkg::QPTR_W+1)'(wr_en) - (psd_pkg::QPTR_W+1)'(rd_en);

    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.kind  = r_q_kind[r_rd_ptr];
    assign o_sample    = r_q_sample[r_rd_ptr];
    assign o_square    = r_q_square[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q_kind[r_wr_ptr]   <= kind;
            r_q_sample[r_wr_ptr] <= i_sample;
            r_q_square[r_wr_ptr] <= sq_full[SQ_W-1:0];
        end
    end

endmodule

@@ rtl/core/psd_back.sv @@
// back end: accumulators, finish sequencer (multiply, root, divide), result register
`include "population_std_deviation_top_macros.svh"

module psd_back #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  psd_pkg::t_cmd_ctl                     i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    input  logic [2*SAMPLE_WIDTH-2:0]             i_square,
    output logic                                  o_take,
    input  logic                                  i_pop,
    output logic                                  o_empty,
    output logic [psd_pkg::STD_W-1:0]             o_std_dev,
    output logic [psd_pkg::CNT_OUT_W-1:0]         o_sample_count,
    output logic                                  o_empty_set,
    output logic                                  o_overflowed
);

    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + CW;
    localparam int SSQ_W  = 2 * SAMPLE_WIDTH - 2 + CW;
    localparam int D_W    = SSQ_W + CW;
    localparam int R_W    = (D_W + 1) / 2;
    localparam int ACC_W  = 2 * R_W;
    localparam int REM_W  = R_W + 2;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int Q_W    = (R_W > psd_pkg::STD_W) ? R_W : psd_pkg::STD_W;

    psd_pkg::t_state             r_state, n_state;
    logic signed [SUM_W-1:0]     r_sum, n_sum;
    logic [SSQ_W-1:0]            r_ssq, n_ssq;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_drop, n_drop;
    logic [STEP_W-1:0]           r_step, n_step;
    logic                        r_out_vld, n_out_vld;

    logic [CW-1:0]               r_n, n_n;
    logic [SUM_W-1:0]            r_abs, n_abs;
    logic [ACC_W-1:0]            r_acc, n_acc;
    logic [ACC_W-1:0]            r_mcand, n_mcand;
    logic [SUM_W-1:0]            r_mplier, n_mplier;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [R_W-1:0]              r_root, n_root;
    logic [CW-1:0]               r_drem, n_drem;
    logic                        r_res_drop, n_res_drop;
    logic [CW-1:0]               r_res_count, n_res_count;
    logic [psd_pkg::STD_W-1:0]   r_out_std, n_out_std;
    logic [psd_pkg::CNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                        r_out_empty, n_out_empty;
    logic                        r_out_drop, n_out_drop;

    logic                        has_room;
    logic                        do_add;
    logic                        add_ok;
    logic                        is_fin;
    logic signed [SUM_W-1:0]     u_sum;
    logic [SSQ_W-1:0]            u_ssq;
    logic [CW-1:0]               u_count;
    logic                        u_drop;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;
    logic                        sq_ge;
    logic [CW:0]                 d_sh;
    logic                        dv_ge;
    logic [Q_W-1:0]              q_ext;
    logic                        sat;
    logic [psd_pkg::STD_W-1:0]   std_val;

    assign o_take   = (r_state == psd_pkg::S_IDLE) && i_cmd.valid;
    assign has_room = (r_count < CW'(MAX_SAMPLES));
    assign do_add   = o_take && (i_cmd.kind != psd_pkg::K_FIN);
    assign add_ok   = do_add && has_room;
    assign is_fin   = o_take && (i_cmd.kind != psd_pkg::K_ADD);

    // accumulator values including the sample of this word
    assign u_sum   = add_ok ? r_sum + SUM_W'(i_sample) : r_sum;
    assign u_ssq   = add_ok ? r_ssq + SSQ_W'(i_square) : r_ssq;
    assign u_count = add_ok ? r_count + 1'b1 : r_count;
    assign u_drop  = r_drop || (do_add && !has_room);

    // root step: bring down two radicand bits
    assign rem_sh = {r_rem[REM_W-3:0], r_acc[ACC_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // divide step: bring down one root bit
    assign d_sh  = {r_drem, r_root[R_W-1]};
    assign dv_ge = (d_sh >= {1'b0, r_n});

    assign q_ext   = Q_W'(r_root);
    assign sat     = |(q_ext >> psd_pkg::STD_W);
    assign std_val = sat ? '1 : q_ext[psd_pkg::STD_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_ssq       = r_ssq;
        n_count     = r_count;
        n_drop      = r_drop;
        n_step      = r_step;
        n_n         = r_n;
        n_abs       = r_abs;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_rem       = r_rem;
        n_root      = r_root;
        n_drem      = r_drem;
        n_res_drop  = r_res_drop;
        n_res_count = r_res_count;
        n_out_vld   = r_out_vld && !i_pop;
        n_out_std   = r_out_std;
        n_out_count = r_out_count;
        n_out_empty = r_out_empty;
        n_out_drop  = r_out_drop;
        case (r_state)
            psd_pkg::S_IDLE: begin
                if (o_take) begin
                    n_sum   = u_sum;
                    n_ssq   = u_ssq;
                    n_count = u_count;
                    n_drop  = u_drop;
                    if (is_fin) begin
                        n_sum       = '0;
                        n_ssq       = '0;
                        n_count     = '0;
                        n_drop      = 1'b0;
                        n_n         = u_count;
                        n_abs       = u_sum[SUM_W-1] ? $unsigned(-u_sum) : $unsigned(u_sum);
                        n_acc       = '0;
                        n_mcand     = ACC_W'(u_ssq);
                        n_mplier    = SUM_W'(u_count);
                        n_step      = '0;
                        n_root      = '0;
                        n_res_drop  = u_drop;
                        n_res_count = u_count;
                        if (u_count == '0) begin
                            n_state = psd_pkg::S_DONE;
                        end else begin
                            n_state = psd_pkg::S_MUL_N;
                        end
                    end
                end
            end
            psd_pkg::S_MUL_N: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(CW - 1)) begin
                    n_mcand  = ACC_W'(r_abs);
                    n_mplier = r_abs;
                    n_step   = '0;
                    n_state  = psd_pkg::S_MUL_S;
                end
            end
            psd_pkg::S_MUL_S: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc - r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = psd_pkg::S_SQRT;
                end
            end
            psd_pkg::S_SQRT: begin
                n_rem  = sq_ge ? rem_sh - trial : rem_sh;
                n_root = {r_root[R_W-2:0], sq_ge};
                n_acc  = r_acc << 2;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(R_W - 1)) begin
                    n_drem  = '0;
                    n_step  = '0;
                    n_state = psd_pkg::S_DIV;
                end
            end
            psd_pkg::S_DIV: begin
                n_drem = dv_ge ? CW'(d_sh - {1'b0, r_n}) : d_sh[CW-1:0];
                n_root = {r_root[R_W-2:0], dv_ge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(R_W - 1)) begin
                    n_state = psd_pkg::S_DONE;
                end
            end
            psd_pkg::S_DONE: begin
                if (!r_out_vld || i_pop) begin
                    n_out_vld   = 1'b1;
                    n_out_std   = std_val;
                    n_out_count = psd_pkg::CNT_OUT_W'(r_res_count);
                    n_out_empty = (r_res_count == '0);
                    n_out_drop  = r_res_drop;
                    n_state     = psd_pkg::S_IDLE;
                end
            end
            default: n_state = psd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psd_pkg::S_IDLE;
            r_sum     <= '0;
            r_ssq     <= '0;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_ssq     <= n_ssq;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_abs       <= n_abs;
        r_acc       <= n_acc;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_drem      <= n_drem;
        r_res_drop  <= n_res_drop;
        r_res_count <= n_res_count;
        r_out_std   <= n_out_std;
        r_out_count <= n_out_count;
        r_out_empty <= n_out_empty;
        r_out_drop  <= n_out_drop;
    end

    assign o_empty        = !r_out_vld;
    assign o_std_dev      = r_out_std;
    assign o_sample_count = r_out_count;
    assign o_empty_set    = r_out_empty;
    assign o_overflowed   = r_out_drop;

    `PSD_ASSERT_IMP(a_empty_gives_zero, i_clk, i_rst_n, r_out_vld && r_out_empty, r_out_std == '0)
    `PSD_ASSERT_NXT(a_done_holds, i_clk, i_rst_n, (r_state == psd_pkg::S_DONE) && r_out_vld && !i_pop, r_state == psd_pkg::S_DONE)
    `PSD_ASSERT_NXT(a_finish_clears, i_clk, i_rst_n, is_fin, (r_count == '0) && !r_drop && (r_sum == '0) && (r_ssq == '0))
    `PSD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_state != psd_pkg::S_IDLE, r_res_count <= CW'(MAX_SAMPLES))

endmodule

@@ verif/psd_deviation_checker.sv @@
`timescale 1ns / 1ps
// checker: predicts the deviation results of the block and compares them field by field
module psd_deviation_checker #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic [psd_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    input  logic                                  i_empty,
    input  logic                                  i_pop,
    input  logic [psd_pkg::STD_W-1:0]             i_std_dev,
    input  logic [psd_pkg::CNT_OUT_W-1:0]         i_sample_count,
    input  logic                                  i_empty_set,
    input  logic                                  i_overflowed,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);

    typedef struct packed {
        logic [psd_pkg::STD_W-1:0]     std_dev;
        logic [psd_pkg::CNT_OUT_W-1:0] sample_count;
        logic                          empty_set;
        logic                          overflowed;
    } t_deviation;

    t_deviation  deviation_q[$];

    // accumulators of the set being built
    longint      acc_sum;
    logic [127:0] acc_sq;
    int unsigned acc_n;
    logic        acc_dropped;

    // bit-serial integer square root, one result bit per pair of input bits
    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            root  = root << 1;
            trial = ({64'd0, root} << 1) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    task automatic take_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
        longint sv;
        sv = longint'(s);
        if (acc_n >= MAX_SAMPLES) begin
            acc_dropped = 1'b1;
        end else begin
            acc_sum = acc_sum + sv;
            acc_sq  = acc_sq + 128'(sv * sv);
            acc_n++;
        end
    endtask

    task automatic clear_set();
        acc_sum     = 0;
        acc_sq      = '0;
        acc_n       = 0;
        acc_dropped = 1'b0;
    endtask

    // floor(isqrt(n*sumsq - sum^2) / n), saturated to the result width
    task automatic close_set();
        t_deviation   r;
        logic [127:0] mag;
        logic [127:0] spread;
        logic [63:0]  quot;
        r = '0;
        if (acc_n != 0) begin
            mag    = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
            spread = acc_sq * 128'(acc_n) - mag * mag;
            quot   = isqrt128(spread) / 64'(acc_n);
            r.std_dev = (quot > 64'({psd_pkg::STD_W{1'b1}})) ? {psd_pkg::STD_W{1'b1}}
                                                              : quot[psd_pkg::STD_W-1:0];
        end
        r.sample_count = acc_n[psd_pkg::CNT_OUT_W-1:0];
        r.empty_set    = (acc_n == 0);
        r.overflowed   = acc_dropped;
        deviation_q.push_back(r);
        clear_set();
    endtask

    task automatic predict_deviation(input logic [psd_pkg::FUNC_W-1:0] f,
                                     input logic signed [SAMPLE_WIDTH-1:0] s);
        case (f)
            psd_pkg::FUNC_ADD: begin
                take_sample(s);
            end
            psd_pkg::FUNC_ADD_FIN: begin
                take_sample(s);
                close_set();
            end
            psd_pkg::FUNC_FIN: begin
                close_set();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_deviation got;
        t_deviation want;
        if (!i_rst_n) begin
            clear_set();
            deviation_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = {i_std_dev, i_sample_count, i_empty_set, i_overflowed};
                if (deviation_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result std_dev=%0d count=%0d empty=%0b ovf=%0b",
                                 $realtime, got.std_dev, got.sample_count, got.empty_set,
                                 got.overflowed);
                end else begin
                    want = deviation_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     $realtime, want.std_dev, want.sample_count,
                                     want.empty_set, want.overflowed, got.std_dev,
                                     got.sample_count, got.empty_set, got.overflowed);
                    end
                end
            end
            if (i_push && !i_full)
                predict_deviation(i_func, i_sample);
        end
        o_pending = deviation_q.size();
    end

endmodule

@@ verif/tb_population_std_deviation_top.sv @@
`timescale 1ns / 1ps
// testbench top: stimulus, handshake timing and verdict for the standard deviation block
module tb_population_std_deviation_top;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_WIDTH = 24;
    // the one func code the block drops without a result
    localparam logic [psd_pkg::FUNC_W-1:0] FUNC_UNDEF = 2'd3;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    // long enough for the command queue and the result register to fill up
    localparam int HOLD_CYCLES = 600;

    logic                             i_clk    = 1'b0;
    logic                             i_rst_n  = 1'b0;
    logic                             push     = 1'b0;
    logic                             pop      = 1'b0;
    logic [psd_pkg::FUNC_W-1:0]       i_func   = '0;
    logic signed [SAMPLE_WIDTH-1:0]   i_sample = '0;
    logic                             full;
    logic                             empty;
    logic [psd_pkg::STD_W-1:0]        o_std_dev;
    logic [psd_pkg::CNT_OUT_W-1:0]    o_sample_count;
    logic                             o_empty_set;
    logic                             o_overflowed;

    // idling knobs, written by the stimulus process only
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int words_sent     = 0;

    int fail_count;
    int pending;
    int checked;

    // 4 ns period
    always #2 i_clk = ~i_clk;

    population_std_deviation_top #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_sample       (i_sample),
        .empty          (empty),
        .pop            (pop),
        .o_std_dev      (o_std_dev),
        .o_sample_count (o_sample_count),
        .o_empty_set    (o_empty_set),
        .o_overflowed   (o_overflowed)
    );

    // predicts and compares every result word; hands back the failure count
    psd_deviation_checker #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_func         (i_func),
        .i_sample       (i_sample),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_std_dev      (o_std_dev),
        .i_sample_count (o_sample_count),
        .i_empty_set    (o_empty_set),
        .i_overflowed   (o_overflowed),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // watchdog: far beyond the slowest legal run (every word a finish plus stalls)
    initial begin
        #4000000;
        $display("** population_std_deviation_top: FAILED **");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here
    initial begin : receiver
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_taken) begin
                // block the result side while the sender keeps pushing finishes
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one word, called at a falling edge, returns at a falling edge after acceptance
    task automatic put_word(input logic [psd_pkg::FUNC_W-1:0] f,
                            input logic signed [SAMPLE_WIDTH-1:0] s);
        // random sender gaps; push only drops when a gap is taken
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push     <= 1'b1;
        i_func   <= f;
        i_sample <= s;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // raw random sample over the whole range
    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        return SAMPLE_WIDTH'($urandom);
    endfunction

    // mostly samples clustered around the set's base, some extremes and raw noise
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input int base,
                                                                   input int spread);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return SAMPLE_MIN;
        else if (r == 1)
            return SAMPLE_MAX;
        else if (r < 4)
            return rand_sample();
        else
            return SAMPLE_WIDTH'(base + int'($urandom_range(spread)) - spread / 2);
    endfunction

    // one well-formed set, closed either by an add-finish or by a separate finish,
    // with an occasional dropped func code mixed in
    task automatic run_set(input int n_samples, input bit fin_alone);
        int base;
        int spread;
        base   = int'($urandom);
        spread = 1 << $urandom_range(20);
        for (int k = 0; k < n_samples; k++) begin
            if ($urandom_range(99) < 6)
                put_word(FUNC_UNDEF, rand_sample());
            if (k == n_samples - 1 && !fin_alone)
                put_word(psd_pkg::FUNC_ADD_FIN, pick_sample(base, spread));
            else
                put_word(psd_pkg::FUNC_ADD, pick_sample(base, spread));
        end
        if (fin_alone)
            put_word(psd_pkg::FUNC_FIN, rand_sample());
    endtask

    // random sets under one idling setting; set sizes mostly small, a few longer
    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int done;
        int p;
        int size;
        bit fin_alone;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done = 0;
        while (done < n_items) begin
            p = $urandom_range(99);
            fin_alone = ($urandom_range(2) == 0);
            if (p < 5) begin
                // empty set
                put_word(psd_pkg::FUNC_FIN, rand_sample());
                done++;
            end else begin
                if (p < 80)
                    size = $urandom_range(12, 1);
                else if (p < 96)
                    size = $urandom_range(24, 13);
                else
                    size = $urandom_range(40, 25);
                run_set(size, fin_alone);
                done += size + int'(fin_alone);
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty set straight after reset, then a dropped code
        put_word(psd_pkg::FUNC_FIN, '0);
        put_word(FUNC_UNDEF, SAMPLE_MAX);
        // single sample at the negative extreme gives zero deviation
        put_word(psd_pkg::FUNC_ADD_FIN, SAMPLE_MIN);
        // widest possible spread
        put_word(psd_pkg::FUNC_ADD, SAMPLE_MAX);
        put_word(psd_pkg::FUNC_ADD_FIN, SAMPLE_MIN);
        // small symmetric set, a dropped code inside it, finish sample ignored
        put_word(psd_pkg::FUNC_ADD, '0);
        put_word(FUNC_UNDEF, SAMPLE_MIN);
        put_word(psd_pkg::FUNC_ADD, 24'sd256);
        put_word(psd_pkg::FUNC_ADD, -24'sd256);
        put_word(psd_pkg::FUNC_FIN, SAMPLE_MAX);
        // back to back finish: the first one cleared everything
        put_word(psd_pkg::FUNC_FIN, '0);
        // equal negative samples
        put_word(psd_pkg::FUNC_ADD, -24'sd1);
        put_word(psd_pkg::FUNC_ADD, -24'sd1);
        put_word(psd_pkg::FUNC_ADD_FIN, -24'sd1);
        // large negative sum
        repeat (3) put_word(psd_pkg::FUNC_ADD, SAMPLE_MIN);
        put_word(psd_pkg::FUNC_ADD_FIN, SAMPLE_MAX);

        // pressure: results held off while finishes keep coming, so full must rise
        hold_req = 1'b1;
        repeat (10) begin
            put_word(psd_pkg::FUNC_ADD, rand_sample());
            put_word(psd_pkg::FUNC_ADD_FIN, rand_sample());
        end

        // full capacity of alternating extremes, then dropped adds and a dropped add-finish
        for (int k = 0; k < MAX_SAMPLES; k++)
            put_word(psd_pkg::FUNC_ADD, k[0] ? SAMPLE_MAX : SAMPLE_MIN);
        repeat (2) put_word(psd_pkg::FUNC_ADD, rand_sample());
        put_word(psd_pkg::FUNC_ADD_FIN, rand_sample());
        // that finish also cleared the overflow flag
        put_word(psd_pkg::FUNC_FIN, rand_sample());

        // random sets under each idling setting
        run_phase(0, 0, 40);
        run_phase(58, 0, 40);
        run_phase(0, 58, 40);
        run_phase(19, 19, 40);

        push <= 1'b0;
        recv_stall_pct = 0;
        wait (pending == 0);
        // room for a late or extra result after the last finish
        repeat (200) @(posedge i_clk);

        $display("covered %0d words: all func codes, empty sets, a full set with overflow,",
                 words_sent);
        $display("a %0d-cycle result hold-off and four idling mixes; %0d results checked",
                 HOLD_CYCLES, checked);
        if (fail_count == 0) begin
            $display("** population_std_deviation_top: PASSED **");
        end else begin
            $display("** population_std_deviation_top: FAILED **");
        end
        $finish;
    end

endmodule
